// ===== hw/rtl/ibwf_pkg.sv =====
// Shared types, constants and the falloff table of the ink-bleed window filter.
// No dependencies; imported by ibwf_div, ink_bleed_window_filter and tb.
package ibwf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 3;

    // shared long-division unit
    localparam int DIV_NUM_W  = 25;
    localparam int DIV_DEN_W  = 13;
    localparam int DIV_STEP_W = 5;

    // add = floor(floor(P / 2^24) / 100), the /100 by reciprocal
    localparam int         ALPHA_SHIFT = 24;
    localparam logic [13:0] RECIP_100  = 14'd10486;
    localparam int         RECIP_SHIFT = 20;

    // colour quotients never exceed 9 bits
    localparam logic [DIV_STEP_W-1:0] COLOUR_STEPS = 5'd9;
    localparam logic [DIV_STEP_W-1:0] COORD_STEPS  = 5'd25;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STRENGTH     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XYS,
        ST_XYW,
        ST_BASE,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_FIN,
        ST_DIVS,
        ST_DIVW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

    // max(0, 1 - dist/4) in Q0.16, by |dx| and |dy|; 0 for the centre tap
    function automatic logic [15:0] falloff(input logic [1:0] ax, input logic [1:0] ay);
        logic [15:0] w;
        case ({ax, ay})
            4'h0: w = 16'd0;
            4'h1: w = 16'd49152;
            4'h2: w = 16'd32768;
            4'h3: w = 16'd16384;
            4'h4: w = 16'd49152;
            4'h5: w = 16'd42366;
            4'h6: w = 16'd28900;
            4'h7: w = 16'd13725;
            4'h8: w = 16'd32768;
            4'h9: w = 16'd28900;
            4'ha: w = 16'd19195;
            4'hb: w = 16'd6463;
            4'hc: w = 16'd16384;
            4'hd: w = 16'd13725;
            4'he: w = 16'd6463;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/ibwf_div.sv =====
// Restoring long divider, one quotient bit a cycle, shared by the filter.
// Depends on ibwf_pkg (request and response structs).
module ibwf_div
    import ibwf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0]  sh_reg;
    logic [DIV_NUM_W-1:0]  quo_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic                  done_reg;

    logic [DIV_DEN_W:0]    trial;
    logic                  ge;

    // caller guarantees num >> steps < den
    assign trial = {rem_reg, sh_reg[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == DIV_STEP_W'(1));
            if (req.start)
                cnt_reg <= req.steps;
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DIV_DEN_W'(req.num >> req.steps);
            sh_reg  <= req.num << (DIV_STEP_W'(DIV_NUM_W) - req.steps);
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : DIV_DEN_W'(trial);
            sh_reg  <= {sh_reg[DIV_NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    busy_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> (cnt_reg != '0) || $past(req.steps == '0))
        else $error("divider did not start");
    no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > DIV_STEP_W'(1)) |-> !req.start)
        else $error("divider restarted mid-division");
    done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == DIV_STEP_W'(1)) && !req.start |=> done_reg)
        else $error("divider done pulse missing");

endmodule

// ===== hw/rtl/ink_bleed_window_filter.sv =====
// Ink-bleed window filter: top level, line-store memory, window sequencer.
// Depends on ibwf_pkg and ibwf_div.
//
// Usage
//   s_*   : input transactions. s_tuser is the command (0 pixel, 1 flush),
//           s_tdata the ARGB pixel. Pixels of a frame arrive in raster order.
//   m_*   : result transactions, blended ARGB in m_tdata, m_tlast on the
//           final pixel of the frame.
//   cfg_* : register writes (0 width, 1 height, 2 strength Q2.8), only while
//           idle; cfg_ready is always high.
// Pixel j leaves once pixel j + 3*width + 3 has come in, or on a flush.
// Release: an item that releases nothing is taken while idle. An item that
//   releases a pixel is followed by the column/row division, one memory read
//   per window tap through the single read port, a drain of the multiply
//   pipeline, then six colour divisions on the shared divider (three when the
//   base pixel is transparent, none without ink); at radius 0 the pixel passes
//   straight through. No further item is taken until the release is done.
// Reset clears the counters, state and configuration registers (width 1024, height 1, strength 0);
//   the line store holds no reset value and needs no clearing pass.
// Stall: the result sits in an output register; items are still taken
//   while it waits, and the sequencer holds its next result until the
//   register frees.
module ink_bleed_window_filter
    import ibwf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] pixel_argb
    input  logic        s_tuser,    // [0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] out_argb
    output logic        m_tlast,    // last_pixel
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int RING   = 7 * MAX_WIDTH;
    localparam int AW     = $clog2(RING);
    localparam int WMAX   = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int CNT_W  = $clog2(WMAX * 8191 + 1);
    localparam int CW     = 25;
    localparam logic signed [AW+1:0] RING_S = (AW+2)'(RING);
    localparam logic [1:0] RAD_MAX = 2'(MAX_RADIUS);

    function automatic logic [AW-1:0] wrap(input logic signed [AW+1:0] v);
        logic signed [AW+1:0] r;
        r = v;
        if (v < 0)
            r = v + RING_S;
        else if (v >= RING_S)
            r = v - RING_S;
        return AW'(r);
    endfunction

    // ---------------- configuration ----------------
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [9:0]  strength_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd1024;
            image_height_reg <= 13'd1;
            strength_reg     <= 10'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_STRENGTH:     strength_reg     <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [23:0] total;
    logic [12:0] lag_thr;
    logic [3:0]  rad_raw;
    logic [1:0]  rad_cur;
    logic [13:0] q15;

    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = 11'd1;
        else if ({2'b00, image_width_reg} > 13'(MAX_WIDTH))
            w_eff = 11'(MAX_WIDTH);
        else
            w_eff = image_width_reg;
        h_eff   = (image_height_reg == '0) ? 13'd1 : image_height_reg;
        total   = {13'd0, w_eff} * {11'd0, h_eff};
        lag_thr = {1'b0, w_eff, 1'b0} + {2'b00, w_eff} + 13'd3;
        rad_raw = 4'(({2'b00, strength_reg} + 12'd128 + {1'b0, strength_reg, 1'b0}
                      - {2'b00, strength_reg}) >> 8);
        rad_cur = (rad_raw > {2'b00, RAD_MAX}) ? RAD_MAX : rad_raw[1:0];
        q15     = {strength_reg, 4'b0000} - {4'b0000, strength_reg};
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;

    logic [CNT_W-1:0] items_seen_reg, items_seen_next;
    logic [CNT_W-1:0] pixels_emitted_reg, pixels_emitted_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    emit_ptr_reg, emit_ptr_next;

    logic [10:0]      x_reg, x_next;
    logic [12:0]      y_reg, y_next;
    logic [1:0]       rad_reg, rad_next;
    logic [31:0]      base_reg, base_next;
    logic signed [2:0] dx_reg, dx_next;
    logic signed [2:0] dy_reg, dy_next;
    logic signed [CNT_W+1:0] row_idx_reg, row_idx_next;
    logic [AW-1:0]    row_ptr_reg, row_ptr_next;
    logic [1:0]       drain_cnt_reg, drain_cnt_next;
    logic [7:0]       t_reg, t_next;
    logic [7:0]       a2_reg, a2_next;
    logic [2:0]       idx_reg, idx_next;
    logic [31:0]      res_reg, res_next;
    logic [7:0]       ink_reg [3];
    logic [7:0]       fin_reg [3];

    // accumulators
    logic [12:0]      s_reg;
    logic [20:0]      sr_reg, sg_reg, sb_reg;

    // line store
    logic [31:0]      line_mem [RING];
    logic [31:0]      rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             mem_we;

    // multiply pipeline
    logic             v1_reg, v2_reg, v3_reg, v4_reg;
    logic [15:0]      wt1_reg;
    logic [23:0]      p1_reg;
    logic [37:0]      p2_reg;
    logic [27:0]      add_prod;
    logic [7:0]       add_reg;
    logic [23:0]      rgb2_reg, rgb3_reg, rgb4_reg;

    logic             out_valid_reg;
    logic [31:0]      out_data_reg;
    logic             out_last_reg;
    logic             out_free;
    logic             last_flag;

    div_req_t         div_req;
    div_rsp_t         div_rsp;

    ibwf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- window tap decode ----------------
    logic signed [12:0]    nx;
    logic signed [14:0]    ny;
    logic signed [CNT_W+1:0] nidx;
    logic [1:0]            adx, ady;
    logic [15:0]           tap_wt;
    logic                  tap_valid;
    logic [AW-1:0]         tap_addr;
    logic [12:0]           rad_w;
    logic signed [2:0]     rad_s;
    logic                  accept;
    logic                  flush;
    logic [CNT_W-1:0]      items_inc;
    logic [7:0]            base_a;
    logic [7:0]            sel_old, sel_ink;
    logic [8:0]            a_plus_t;

    always_comb
    begin
        rad_s     = $signed({1'b0, rad_reg});
        nx        = $signed({2'b00, x_reg}) + 13'(dx_reg);
        ny        = $signed({2'b00, y_reg}) + 15'(dy_reg);
        nidx      = row_idx_reg + (CNT_W+2)'(dx_reg);
        adx       = dx_reg[2] ? 2'(-dx_reg) : dx_reg[1:0];
        ady       = dy_reg[2] ? 2'(-dy_reg) : dy_reg[1:0];
        tap_wt    = falloff(adx, ady);
        tap_valid = !(dx_reg == 3'sd0 && dy_reg == 3'sd0)
                    && !nx[12] && (nx < $signed({2'b00, w_eff}))
                    && !ny[14] && (ny < $signed({2'b00, h_eff}))
                    && (nidx < $signed({2'b00, items_seen_reg}))
                    && (tap_wt != '0);
        tap_addr  = wrap($signed({2'b00, row_ptr_reg}) + (AW+2)'(dx_reg));
        rad_w     = ({2'b00, w_eff} & {13{rad_cur[0]}})
                  + ({1'b0, w_eff, 1'b0} & {13{rad_cur[1]}});
        accept    = s_tvalid && s_tready;
        flush     = s_tuser || (CW'(items_seen_reg) >= CW'(total));
        items_inc = items_seen_reg + 1'b1;
        base_a    = base_reg[31:24];
        out_free  = !out_valid_reg || m_tready;
        last_flag = (CW'(pixels_emitted_reg) + CW'(1)) >= CW'(total);
        a_plus_t  = {1'b0, base_a} + {1'b0, t_reg};
        case (idx_reg)
            3'd3:    sel_old = base_reg[23:16];
            3'd4:    sel_old = base_reg[15:8];
            default: sel_old = base_reg[7:0];
        endcase
        case (idx_reg)
            3'd3:    sel_ink = ink_reg[0];
            3'd4:    sel_ink = ink_reg[1];
            default: sel_ink = ink_reg[2];
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign mem_we   = accept && !flush;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next          = state_reg;
        items_seen_next     = items_seen_reg;
        pixels_emitted_next = pixels_emitted_reg;
        wr_ptr_next         = wr_ptr_reg;
        emit_ptr_next       = emit_ptr_reg;
        x_next              = x_reg;
        y_next              = y_reg;
        rad_next            = rad_reg;
        base_next           = base_reg;
        dx_next             = dx_reg;
        dy_next             = dy_reg;
        row_idx_next        = row_idx_reg;
        row_ptr_next        = row_ptr_reg;
        drain_cnt_next      = drain_cnt_reg;
        t_next              = t_reg;
        a2_next             = a2_reg;
        idx_next            = idx_reg;
        res_next            = res_reg;
        rd_addr             = emit_ptr_reg;
        div_req             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!flush)
                    begin
                        items_seen_next = items_inc;
                        wr_ptr_next     = wrap($signed({2'b00, wr_ptr_reg}) + (AW+2)'(1));
                        if ((items_inc - pixels_emitted_reg) > CNT_W'(lag_thr))
                            state_next = ST_XYS;
                    end
                    else if (pixels_emitted_reg < items_seen_reg)
                    begin
                        state_next = ST_XYS;
                    end
                end
            end
            ST_XYS:
            begin
                div_req.start = 1'b1;
                div_req.steps = COORD_STEPS;
                div_req.num   = DIV_NUM_W'(pixels_emitted_reg);
                div_req.den   = {2'b00, w_eff};
                state_next    = ST_XYW;
            end
            ST_XYW:
            begin
                if (div_rsp.done)
                begin
                    x_next     = div_rsp.rem[10:0];
                    y_next     = div_rsp.quo[12:0];
                    rad_next   = rad_cur;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                rd_addr    = emit_ptr_reg;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                base_next    = rd_data_reg;
                dx_next      = -rad_s;
                dy_next      = -rad_s;
                row_idx_next = $signed({2'b00, pixels_emitted_reg})
                             - $signed((CNT_W+2)'(rad_w));
                row_ptr_next = wrap($signed({2'b00, emit_ptr_reg})
                                    - $signed((AW+2)'(rad_w)));
                if (rad_reg == '0)
                begin
                    res_next   = rd_data_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_addr = tap_addr;
                if (dx_reg == rad_s)
                begin
                    dx_next      = -rad_s;
                    dy_next      = dy_reg + 3'sd1;
                    row_idx_next = row_idx_reg + (CNT_W+2)'(w_eff);
                    row_ptr_next = wrap($signed({2'b00, row_ptr_reg}) + (AW+2)'(w_eff));
                    if (dy_reg == rad_s)
                    begin
                        drain_cnt_next = '0;
                        state_next     = ST_DRAIN;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 3'sd1;
                end
            end
            ST_DRAIN:
            begin
                drain_cnt_next = drain_cnt_reg + 1'b1;
                if (drain_cnt_reg == 2'd3)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (s_reg == '0)
                begin
                    res_next   = base_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    t_next     = (s_reg > 13'd255) ? 8'd255 : s_reg[7:0];
                    idx_next   = '0;
                    state_next = ST_DIVS;
                end
            end
            ST_DIVS:
            begin
                a2_next       = a_plus_t[8] ? 8'd255 : a_plus_t[7:0];
                div_req.start = 1'b1;
                div_req.steps = COLOUR_STEPS;
                case (idx_reg)
                    3'd0:
                    begin
                        div_req.num = DIV_NUM_W'(sr_reg);
                        div_req.den = s_reg;
                    end
                    3'd1:
                    begin
                        div_req.num = DIV_NUM_W'(sg_reg);
                        div_req.den = s_reg;
                    end
                    3'd2:
                    begin
                        div_req.num = DIV_NUM_W'(sb_reg);
                        div_req.den = s_reg;
                    end
                    default:
                    begin
                        div_req.num = DIV_NUM_W'({1'b0, {8'd0, sel_old} * {8'd0, base_a}}
                                               + {1'b0, {8'd0, sel_ink} * {8'd0, t_reg}});
                        div_req.den = DIV_DEN_W'(a2_reg);
                    end
                endcase
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_rsp.done)
                begin
                    if (idx_reg == 3'd2 && base_a == '0)
                    begin
                        res_next   = {a2_reg, ink_reg[0], ink_reg[1], div_rsp.quo[7:0]};
                        state_next = ST_OUT;
                    end
                    else if (idx_reg == 3'd5)
                    begin
                        res_next   = {a2_reg, fin_reg[0], fin_reg[1], div_rsp.quo[7:0]};
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (last_flag)
                    begin
                        items_seen_next     = '0;
                        pixels_emitted_next = '0;
                        wr_ptr_next         = '0;
                        emit_ptr_next       = '0;
                    end
                    else
                    begin
                        pixels_emitted_next = pixels_emitted_reg + 1'b1;
                        emit_ptr_next = wrap($signed({2'b00, emit_ptr_reg}) + (AW+2)'(1));
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            items_seen_reg     <= '0;
            pixels_emitted_reg <= '0;
            wr_ptr_reg         <= '0;
            emit_ptr_reg       <= '0;
            drain_cnt_reg      <= '0;
            idx_reg            <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            items_seen_reg     <= items_seen_next;
            pixels_emitted_reg <= pixels_emitted_next;
            wr_ptr_reg         <= wr_ptr_next;
            emit_ptr_reg       <= emit_ptr_next;
            drain_cnt_reg      <= drain_cnt_next;
            idx_reg            <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        rad_reg     <= rad_next;
        base_reg    <= base_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        row_idx_reg <= row_idx_next;
        row_ptr_reg <= row_ptr_next;
        t_reg       <= t_next;
        a2_reg      <= a2_next;
        res_reg     <= res_next;
        if (state_reg == ST_DIVW && div_rsp.done)
        begin
            case (idx_reg)
                3'd0: ink_reg[0] <= div_rsp.quo[7:0];
                3'd1: ink_reg[1] <= div_rsp.quo[7:0];
                3'd2: ink_reg[2] <= div_rsp.quo[7:0];
                3'd3: fin_reg[0] <= div_rsp.quo[7:0];
                3'd4: fin_reg[1] <= div_rsp.quo[7:0];
                default: fin_reg[2] <= div_rsp.quo[7:0];
            endcase
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[wr_ptr_reg] <= s_tdata;
        rd_data_reg <= line_mem[rd_addr];
    end

    // ---------------- tap pipeline ----------------
    assign add_prod = p2_reg[37:ALPHA_SHIFT] * RECIP_100;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (state_reg == ST_SCAN) && tap_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wt1_reg  <= tap_wt;
        p1_reg   <= rd_data_reg[31:24] * wt1_reg;
        rgb2_reg <= rd_data_reg[23:0];
        p2_reg   <= p1_reg * q15;
        rgb3_reg <= rgb2_reg;
        add_reg  <= add_prod[RECIP_SHIFT+7:RECIP_SHIFT];
        rgb4_reg <= rgb3_reg;
        if (state_reg == ST_INIT)
        begin
            s_reg  <= '0;
            sr_reg <= '0;
            sg_reg <= '0;
            sb_reg <= '0;
        end
        else if (v4_reg)
        begin
            s_reg  <= s_reg + {5'd0, add_reg};
            sr_reg <= sr_reg + {5'd0, {8'd0, add_reg} * {8'd0, rgb4_reg[23:16]}};
            sg_reg <= sg_reg + {5'd0, {8'd0, add_reg} * {8'd0, rgb4_reg[15:8]}};
            sb_reg <= sb_reg + {5'd0, {8'd0, add_reg} * {8'd0, rgb4_reg[7:0]}};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg <= res_reg;
            out_last_reg <= last_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- checks ----------------
    emitted_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        pixels_emitted_reg <= items_seen_reg)
        else $error("emitted more pixels than received");
    ptrs_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (AW+1)'(wr_ptr_reg) < (AW+1)'(RING) && (AW+1)'(emit_ptr_reg) < (AW+1)'(RING))
        else $error("ring pointer out of range");
    pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("tap pipeline busy after drain");
    result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");
    div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_XYW || state_reg == ST_DIVW))
        else $error("divider finished while not awaited");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for ink_bleed_window_filter: stream driver, result monitor,
// transaction-level predictor of the ink-bleed blend. Depends on ibwf_pkg and the RTL.
module tb
    import ibwf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW      = 1024;
    localparam int RING      = 7 * MAXW;
    localparam int IDLE_WAIT = 400;     // settle time for a release still in flight
    localparam int WD_LIMIT  = 20000;   // cycles with no transaction at all

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // falloff in Q0.16 by |dx|, |dy|
    localparam logic [15:0] FALL [0:3][0:3] = '{
        '{16'd0,     16'd49152, 16'd32768, 16'd16384},
        '{16'd49152, 16'd42366, 16'd28900, 16'd13725},
        '{16'd32768, 16'd28900, 16'd19195, 16'd6463},
        '{16'd16384, 16'd13725, 16'd6463,  16'd0}
    };

    typedef struct packed
    {
        logic        cmd;
        logic [31:0] argb;
    } pix_item_t;

    typedef struct packed
    {
        logic [31:0] argb;
        logic        last;
    } blend_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    ink_bleed_window_filter u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // predictor state: mirror of the block's registers, counters and pixel ring
    logic [31:0] ring_px [RING];
    int unsigned n_seen, n_out;
    logic [10:0] reg_w;
    logic [12:0] reg_h;
    logic [9:0]  reg_str;

    pix_item_t   pend_items[$];
    blend_res_t  exp_blend[$];
    int          n_errors;
    int          n_pixels, n_flush, n_results, n_frames;
    int          idle_cnt;
    bit          hold_on;     // long receiver hold-off requested
    bit          s_taken;     // input transaction at the last rising edge

    function automatic int unsigned width_eff();
        int unsigned w;
        w = reg_w;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int unsigned height_eff();
        return (reg_h == 0) ? 1 : reg_h;
    endfunction

    // blended colour of pixel j from its received neighbours
    function automatic logic [31:0] blend_pixel(int unsigned j);
        int unsigned w, h, rad, a, a2, t, nidx;
        int          x, y, nx, ny, dx, dy;
        logic [31:0] base, src;
        longint unsigned s, sr, sg, sb, add, wt;
        int unsigned ir, ig, ib, nr, ng, nb;
        w = width_eff();
        h = height_eff();
        base = ring_px[j % RING];
        rad = (2 * reg_str + 128) >> 8;
        if (rad > 3) rad = 3;
        if (rad == 0) return base;
        x = j % w;
        y = j / w;
        s = 0; sr = 0; sg = 0; sb = 0;
        for (dy = -int'(rad); dy <= int'(rad); dy++)
            for (dx = -int'(rad); dx <= int'(rad); dx++)
            begin
                nx = x + dx;
                ny = y + dy;
                if (dx == 0 && dy == 0) continue;
                if (nx < 0 || nx >= int'(w) || ny < 0 || ny >= int'(h)) continue;
                nidx = ny * w + nx;
                if (nidx >= n_seen) continue;
                wt = FALL[dx < 0 ? -dx : dx][dy < 0 ? -dy : dy];
                if (wt == 0) continue;
                src = ring_px[nidx % RING];
                add = (longint'(src[31:24]) * reg_str * wt * 15) / 64'd1677721600;
                if (add == 0) continue;
                s  += add;
                sr += add * src[23:16];
                sg += add * src[15:8];
                sb += add * src[7:0];
            end
        if (s == 0) return base;
        t  = (s > 255) ? 255 : s;
        ir = (sr / s) & 8'hff;
        ig = (sg / s) & 8'hff;
        ib = (sb / s) & 8'hff;
        a  = base[31:24];
        a2 = (a + t > 255) ? 255 : a + t;
        if (a == 0) return {a2[7:0], ir[7:0], ig[7:0], ib[7:0]};
        nr = (base[23:16] * a + ir * t) / a2;
        ng = (base[15:8] * a + ig * t) / a2;
        nb = (base[7:0] * a + ib * t) / a2;
        return {a2[7:0], nr[7:0], ng[7:0], nb[7:0]};
    endfunction

    // advance the predictor by one accepted transaction
    task automatic predict_item(input pix_item_t it);
        int unsigned w, total;
        bit flush, emit;
        blend_res_t r;
        w = width_eff();
        total = w * height_eff();
        flush = (it.cmd == CMD_FLUSH) || (n_seen >= total);
        emit = 0;
        if (!flush)
        begin
            ring_px[n_seen % RING] = it.argb;
            n_seen++;
            if (n_seen - n_out > 3 * w + 3) emit = 1;
        end
        else if (n_out < n_seen)
            emit = 1;
        if (emit)
        begin
            r.argb = blend_pixel(n_out);
            n_out++;
            r.last = 1'b0;
            if (n_out >= total)
            begin
                r.last = 1'b1;
                n_seen = 0;
                n_out = 0;
            end
            exp_blend.push_back(r);
        end
    endtask

    // gap length: mostly short, sometimes long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
        s_taken <= s_tvalid && s_tready;

    // driver: takes items from the pending queue, inputs change on the falling edge
    int drv_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            drv_gap = 0;
        end
        else if (s_tvalid && !s_taken)
        begin
            // hold the offered item
        end
        else if (drv_gap > 0)
        begin
            drv_gap--;
            s_tvalid <= 1'b0;
        end
        else if (pend_items.size() > 0)
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= pend_items[0].cmd;
            s_tdata  <= pend_items[0].argb;
            void'(pend_items.pop_front());
            drv_gap = gap_len();
        end
        else
            s_tvalid <= 1'b0;
    end

    // receiver back-pressure, with a separately counted long hold-off
    int rx_gap;
    int hold_cnt;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap = 0;
            hold_cnt = 0;
        end
        else if (hold_on && hold_cnt < 2000)
        begin
            hold_cnt++;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!hold_on || hold_cnt >= 2000) rx_gap = gap_len();
        end
    end

    // monitor: predicts on each input transaction, checks each result transaction
    blend_res_t want;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cnt = idle_cnt + 1;
            if (s_tvalid && s_tready)
            begin
                idle_cnt = 0;
                predict_item('{cmd: s_tuser, argb: s_tdata});
                if (s_tuser == CMD_FLUSH) n_flush++;
                else n_pixels++;
            end
            if (m_tvalid && m_tready)
            begin
                idle_cnt = 0;
                n_results++;
                if (exp_blend.size() == 0)
                begin
                    $error("unexpected result argb=%h last=%b", m_tdata, m_tlast);
                    n_errors++;
                end
                else
                begin
                    want = exp_blend.pop_front();
                    if (m_tdata !== want.argb)
                    begin
                        $error("out_argb: expected %h, got %h", want.argb, m_tdata);
                        n_errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_pixel: expected %b, got %b", want.last, m_tlast);
                        n_errors++;
                    end
                    if (m_tlast === 1'b1) n_frames++;
                end
            end
            if (idle_cnt > WD_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH:  reg_w = val[10:0];
            CFG_IMAGE_HEIGHT: reg_h = val;
            CFG_STRENGTH:     reg_str = val[9:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int w, input int h, input int str);
        cfg_write(CFG_IMAGE_WIDTH, 13'(w));
        cfg_write(CFG_IMAGE_HEIGHT, 13'(h));
        cfg_write(CFG_STRENGTH, 13'(str));
    endtask

    // wait until every queued item is taken and every result has come,
    // then let a release still in flight settle
    task automatic drain_all();
        while (pend_items.size() > 0 || s_tvalid || exp_blend.size() > 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_argb();
        logic [31:0] v;
        int p;
        v = $urandom;
        p = $urandom_range(0, 9);
        if (p == 0) v[31:24] = 8'h00;
        else if (p == 1) v[31:24] = 8'hff;
        return v;
    endfunction

    task automatic push_pixels(input int n);
        for (int i = 0; i < n; i++)
            pend_items.push_back('{cmd: CMD_PIXEL, argb: rnd_argb()});
    endtask

    task automatic push_flush();
        pend_items.push_back('{cmd: CMD_FLUSH, argb: $urandom});
    endtask

    // one frame of random content; sometimes cut short by a flush,
    // sometimes overrun so the excess pixels act as flushes
    task automatic random_frame(input int w, input int h, input int str);
        int tot, n;
        set_geometry(w, h, str);
        tot = w * h;
        n = tot;
        case ($urandom_range(0, 5))
            0: n = $urandom_range(1, tot);
            1: n = tot + $urandom_range(1, 3);
            default: ;
        endcase
        push_pixels(n);
        if (n < tot || $urandom_range(0, 1)) push_flush();
        drain_all();
    endtask

    int fw, fh;
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_PIXEL;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        n_seen = 0; n_out = 0;
        reg_w = 11'd1024; reg_h = 13'd1; reg_str = 10'd0;
        n_errors = 0; n_pixels = 0; n_flush = 0; n_results = 0; n_frames = 0;
        idle_cnt = 0;
        hold_on = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: flush with nothing pending at reset geometry
        push_flush();
        drain_all();
        // extremes of pixel values, maximum strength, 3x3 frame
        set_geometry(3, 3, 1023);
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'h00000000});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'hffffffff});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'h00ffffff});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'hff000000});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'h80123456});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'h01ff00ff});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'hff00ff00});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'h7f7f7f7f});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'haaaaaaaa});
        pend_items.push_back('{cmd: CMD_PIXEL, argb: 32'h55555555}); // frame full
        push_flush();
        drain_all();
        // zero strength passes pixels through; width and height zero act as one
        set_geometry(0, 0, 0);
        push_pixels(2);
        drain_all();
        // width above the store limit, one row, radius zero then one, partial frames flushed
        set_geometry(2047, 1, 63);
        push_pixels(3);
        push_flush();
        drain_all();
        cfg_write(CFG_STRENGTH, 13'd64);
        push_pixels(2);
        push_flush();
        push_flush();
        drain_all();

        // long receiver hold-off while the sender keeps offering
        set_geometry(2, 6, 500);
        hold_on = 1;
        push_pixels(12);
        while (pend_items.size() > 0 || s_tvalid) @(posedge clk);
        hold_on = 0;
        drain_all();

        // random frames, mostly small, a few wider
        while (n_pixels + n_flush < 500)
        begin
            fw = $urandom_range(1, 6);
            fh = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) fw = $urandom_range(7, 16);
            random_frame(fw, fh, $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 1023));
        end
        // one frame at the full width in a single row
        set_geometry(1024, 1, 300);
        push_pixels(6);
        push_flush();
        drain_all();

        $display("covered %0d pixels, %0d flushes, %0d results, %0d frames",
                 n_pixels, n_flush, n_results, n_frames);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== ink_bleed_window_filter.f =====
hw/rtl/ibwf_pkg.sv
hw/rtl/ibwf_div.sv
hw/rtl/ink_bleed_window_filter.sv
tb/tb.sv
